/* rtl/mteb_pkg.sv */
// Package for the multi-timer elapse bank: sizes, command codes, timer phase
// encoding and the structs passed between the top level and the timer cells.
// No dependencies.
`default_nettype none

package mteb_pkg;

  // Number of timers built into the bank (1 to 5).
  localparam int NUM_TIMERS = 5;

  // Fixed field widths.
  localparam int TIME_W    = 16;
  localparam int MASK_W    = 5;
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 3;
  localparam int CFG_IDX_W = 3;

  // Command codes; any other code only returns a status result.
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START = 2'd2;

  // Life cycle of one timer.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_STARTED = 2'd1,
    PH_RUNNING = 2'd2,
    PH_ELAPSED = 2'd3
  } phase_t;

  // Per-cell strobes for one accepted beat.
  typedef struct packed {
    logic scan;
    logic start;
    logic dur_we;
  } cell_ctl_t;

  // Status masks handed along the cell chain.
  typedef struct packed {
    logic [NUM_TIMERS-1:0] elapsed;
    logic [NUM_TIMERS-1:0] running;
  } mask_t;

endpackage

`default_nettype wire

/* rtl/mteb_if.sv */
// Valid/ready channel interfaces of the multi-timer elapse bank: command input,
// status result and duration register writes. Depends on mteb_pkg.
`default_nettype none

interface mteb_in_if import mteb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] timer_index;

  modport source (output valid, output cmd, output timer_index, input ready);
  modport sink   (input valid, input cmd, input timer_index, output ready);
endinterface

interface mteb_out_if import mteb_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] elapsed_mask;
  logic [MASK_W-1:0] running_mask;
  logic [TIME_W-1:0] time_now;

  modport source (output valid, output elapsed_mask, output running_mask, output time_now,
                  input ready);
  modport sink   (input valid, input elapsed_mask, input running_mask, input time_now,
                  output ready);
endinterface

interface mteb_cfg_if import mteb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [TIME_W-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

/* rtl/multi_timer_elapse_bank.sv */
// The result of a command is registered and shown in the cycle after its beat.
// Throughput: one command per cycle; the input is held off only while a result
// waits in the output register and the sink does not take it.
// Every timer cell updates in the same cycle; the status masks pass along the cells.
// Reset (synchronous, rst_n low): time base zero, all timers idle, durations zero,
// no result pending. Duration writes are taken in every cycle.
`default_nettype none

module multi_timer_elapse_bank import mteb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mteb_in_if.sink   in_ch,
  mteb_out_if.source out_ch,
  mteb_cfg_if.sink  cfg_ch
);

  logic              in_acc;
  logic              cfg_acc;
  logic [TIME_W-1:0] time_base_r, time_base_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_elapsed_r, out_running_r;
  logic [TIME_W-1:0] out_time_r;
  mask_t             chain [NUM_TIMERS+1];

  // Handshakes.
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;

  // Time base advances on a tick beat.
  assign time_base_nxt = (in_acc && in_ch.cmd == CMD_TICK) ? time_base_r + 1'b1
                                                           : time_base_r;

  // Row of timer cells; the chain runs from the top cell down to cell 0.
  assign chain[NUM_TIMERS] = '0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    cell_ctl_t ctl;

    always_comb begin
      ctl.scan   = in_acc && in_ch.cmd == CMD_SCAN;
      ctl.start  = in_acc && in_ch.cmd == CMD_START && in_ch.timer_index == IDX_W'(i);
      ctl.dur_we = cfg_acc && cfg_ch.reg_index == CFG_IDX_W'(i);
    end

    mteb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .time_base (time_base_r),
      .dur_wdata (cfg_ch.wdata),
      .mask_in   (chain[i+1]),
      .mask_out  (chain[i])
    );
  end

  // Output register holds the result until the sink takes it.
  assign out_valid_nxt = in_acc || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_base_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      time_base_r <= time_base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_elapsed_r <= MASK_W'(chain[0].elapsed);
      out_running_r <= MASK_W'(chain[0].running);
      out_time_r    <= time_base_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.elapsed_mask = out_elapsed_r;
  assign out_ch.running_mask = out_running_r;
  assign out_ch.time_now     = out_time_r;

`ifndef SYNTHESIS
  // A tick beat moves the time base forward by exactly one.
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.cmd == CMD_TICK |=> time_base_r == TIME_W'($past(time_base_r) + 1'b1))
    else $error("time base did not advance by one on a tick");

  // Without a tick beat the time base holds.
  a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_ch.cmd == CMD_TICK) |=> $stable(time_base_r))
    else $error("time base changed without a tick");

  // A timer is never reported elapsed and running at once.
  a_masks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_elapsed_r & out_running_r) == '0)
    else $error("timer reported both elapsed and running");

  // A pending result always carries the live time base.
  a_time_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_time_r == time_base_r)
    else $error("pending result time differs from time base");
`endif

endmodule

`default_nettype wire

/* rtl/mteb_cell.sv */
// One timer cell: phase, start stamp and duration of a single timer. It adds its
// own status bits to the masks handed in from its neighbor. Depends on mteb_pkg.
`default_nettype none

module mteb_cell import mteb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctl_t         ctl,
  input  wire logic [TIME_W-1:0] time_base,
  input  wire logic [TIME_W-1:0] dur_wdata,
  input  wire mask_t             mask_in,
  output      mask_t             mask_out
);

  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] stamp_r, stamp_nxt;
  logic [TIME_W-1:0] dur_r, dur_nxt;
  logic [TIME_W-1:0] diff;

  // Ticks gone by since the timer began running, modulo the time base width.
  assign diff = time_base - stamp_r;

  // Phase and stamp update for a start or a scan.
  always_comb begin
    phase_nxt = phase_r;
    stamp_nxt = stamp_r;
    if (ctl.start) begin
      phase_nxt = PH_STARTED;
    end else if (ctl.scan) begin
      case (phase_r)
        PH_RUNNING: begin
          if (diff >= dur_r) begin
            phase_nxt = PH_ELAPSED;
          end
        end
        PH_STARTED: begin
          stamp_nxt = time_base;
          phase_nxt = PH_RUNNING;
        end
        default: begin
        end
      endcase
    end
  end

  // Duration register write.
  assign dur_nxt = ctl.dur_we ? dur_wdata : dur_r;

  // Shift this cell's bits in below the neighbor's bits.
  always_comb begin
    mask_out.elapsed = (mask_in.elapsed << 1)
                     | NUM_TIMERS'(phase_nxt == PH_ELAPSED);
    mask_out.running = (mask_in.running << 1)
                     | NUM_TIMERS'(phase_nxt == PH_RUNNING);
  end

  // Control state and duration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dur_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      dur_r   <= dur_nxt;
    end
  end

  // The stamp is only read while running, which needs a scan that loads it.
  always_ff @(posedge clk) begin
    stamp_r <= stamp_nxt;
  end

endmodule

`default_nettype wire
